// ===== design/srfp_pkg.sv =====
package srfp_pkg;

	localparam int DIST_W = 14;
	localparam int TICK_W = 32;
	localparam int CFG_W  = 32;

	localparam logic [7:0]        START_BYTE  = 8'd82;
	localparam logic [7:0]        END_BYTE    = 8'd13;
	localparam logic [7:0]        ASCII_ZERO  = 8'd48;
	localparam logic [7:0]        ASCII_NINE  = 8'd57;
	localparam logic [DIST_W-1:0] DIST_LIMIT  = 14'd9999;
	localparam logic [DIST_W-1:0] DIST_OVER   = 14'd10000;
	localparam logic [DIST_W-1:0] MAX_DIST_RST = 14'd1500;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 32'd1000000;

	typedef enum logic [2:0] {
		ST_FRAME_OK = 3'd0,
		ST_BAD_END  = 3'd1,
		ST_DATA     = 3'd2,
		ST_START    = 3'd3,
		ST_DISCARD  = 3'd4,
		ST_TICK     = 3'd5
	} status_t;

	typedef enum logic {
		MODE_BYTE = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef enum logic {
		REG_MAX_DIST = 1'b0,
		REG_TIMEOUT  = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [DIST_W-1:0] distance;
		logic              fresh;
	} result_t;

	typedef struct packed {
		status_t           status;
		logic              good;
		logic [DIST_W-1:0] distance;
	} frame_out_t;

endpackage

// ===== design/srfp_frame.sv =====
module srfp_frame import srfp_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output frame_out_t res
);

	localparam int CNT_W = $clog2(DIGIT_COUNT + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DIGIT_COUNT);

	logic              in_frame_q;
	logic [CNT_W-1:0]  byte_count_q;
	logic              digits_ok_q;
	logic [DIST_W-1:0] acc_q;
	logic [DIST_W-1:0] last_distance_q;

	logic              in_frame_d;
	logic [CNT_W-1:0]  byte_count_d;
	logic              digits_ok_d;
	logic [DIST_W-1:0] acc_d;
	logic [DIST_W-1:0] last_distance_d;
	logic              is_digit;
	logic [17:0]       acc_mul;
	logic [DIST_W-1:0] acc_sat;
	logic [DIST_W-1:0] decoded;

	assign is_digit = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);

	// running decimal value, saturated just above the limit
	always_comb begin
		acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
			+ {10'd0, rx_byte - ASCII_ZERO};
		acc_sat = (acc_mul > 18'(DIST_LIMIT)) ? DIST_OVER : acc_mul[DIST_W-1:0];
		decoded = (acc_q > DIST_LIMIT) ? DIST_LIMIT : acc_q;
	end

	always_comb begin
		in_frame_d      = in_frame_q;
		byte_count_d    = byte_count_q;
		digits_ok_d     = digits_ok_q;
		acc_d           = acc_q;
		last_distance_d = last_distance_q;
		res.good        = 1'b0;
		res.status      = ST_DISCARD;
		if (in_frame_q && byte_count_q >= CNT_FULL) begin
			if (rx_byte == END_BYTE) begin
				last_distance_d = decoded;
				res.good        = 1'b1;
				res.status      = ST_FRAME_OK;
			end else begin
				res.status = ST_BAD_END;
			end
			in_frame_d   = 1'b0;
			byte_count_d = '0;
		end else if (in_frame_q) begin
			byte_count_d = byte_count_q + CNT_W'(1);
			if (digits_ok_q && is_digit) begin
				acc_d = acc_sat;
			end else begin
				digits_ok_d = 1'b0;
			end
			res.status = ST_DATA;
		end else if (rx_byte == START_BYTE) begin
			in_frame_d   = 1'b1;
			byte_count_d = '0;
			digits_ok_d  = 1'b1;
			acc_d        = '0;
			res.status   = ST_START;
		end else begin
			in_frame_d   = 1'b0;
			byte_count_d = '0;
		end
		res.distance = step ? last_distance_d : last_distance_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q      <= 1'b0;
			byte_count_q    <= '0;
			digits_ok_q     <= 1'b0;
			last_distance_q <= '0;
		end else if (step) begin
			in_frame_q      <= in_frame_d;
			byte_count_q    <= byte_count_d;
			digits_ok_q     <= digits_ok_d;
			last_distance_q <= last_distance_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			acc_q <= acc_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_FULL)
		else $error("frame byte count past digit count");

	a_hunt_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> byte_count_q == '0)
		else $error("byte count nonzero while hunting");

endmodule

// ===== design/sonar_range_frame_parser.sv =====
// sonar range frame parser
// item channel (item_valid/item_ready/item): one word per received serial byte
// (mode 0, byte in rx_byte) or per time tick (mode 1).
// result channel (result_valid/result_ready/result): exactly one word per item,
// carrying status, distance and fresh, in item order.
// a frame is start byte 82, DIGIT_COUNT data bytes, then byte 13; its leading
// ascii digits become the stored distance and restart the tick count.
// cfg port: cfg_we writes cfg_wdata into register cfg_index
// (0 max_dist, 1 timeout_ticks); write only while no item is in flight.
// an accepted item passes the input stage register, then the result register;
// throughput: one item per cycle while result_ready is high (a two-deep
// pipeline), and parsing state updates as an item enters the result register.
// when result_ready is low the result register holds its word, the input
// stage fills, and item_ready drops once both are occupied.
// reset: hunting for a start byte, distance 0, tick count 0, max_dist 1500,
// timeout_ticks 1000000, both channels empty.
module sonar_range_frame_parser import srfp_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic              valid_s1;
	item_t             item_s1;
	logic              advance;
	logic              is_tick;
	logic              frame_step;
	frame_out_t        frame_res;
	logic [DIST_W-1:0] max_dist_q;
	logic [TICK_W-1:0] timeout_q;
	logic [TICK_W-1:0] ticks_q;
	logic [TICK_W-1:0] ticks_d;
	logic              fresh;
	result_t           result_d;

	assign advance    = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign is_tick    = (item_s1.mode == MODE_TICK);
	assign frame_step = advance && !is_tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= MAX_DIST_RST;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_MAX_DIST: max_dist_q <= cfg_wdata[DIST_W-1:0];
				REG_TIMEOUT:  timeout_q  <= cfg_wdata[TICK_W-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	srfp_frame #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (frame_step),
		.rx_byte (item_s1.rx_byte),
		.res     (frame_res)
	);

	always_comb begin
		ticks_d = ticks_q;
		if (is_tick) begin
			if (ticks_q != '1) begin
				ticks_d = ticks_q + TICK_W'(1);
			end
		end else if (frame_res.good) begin
			ticks_d = '0;
		end
		fresh = (ticks_d <= timeout_q);
		result_d.status   = is_tick ? ST_TICK : frame_res.status;
		result_d.distance = fresh ? frame_res.distance : max_dist_q;
		result_d.fresh    = fresh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			if (advance) begin
				ticks_q <= ticks_d;
			end
			if (advance) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= result_d;
		end
	end

	a_good_is_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_FRAME_OK |-> result.fresh)
		else $error("accepted frame reported stale");

	a_good_clears_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_tick && frame_res.good |=> ticks_q == '0)
		else $error("tick count not cleared by good frame");

	a_tick_status: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_tick |=> result_valid && result.status == ST_TICK)
		else $error("tick item did not give tick status");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import srfp_pkg::*;

	localparam int DIGITS = 4;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	item_t            item;
	logic             result_valid;
	logic             result_ready;
	result_t          result;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	sonar_range_frame_parser #(
		.DIGIT_COUNT(DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// parser state mirror
	logic [DIST_W-1:0] mirror_max_dist;
	logic [TICK_W-1:0] mirror_timeout;
	logic              hunt_in_frame;
	int unsigned       hunt_count;
	logic [7:0]        digit_bytes [DIGITS];
	logic [DIST_W-1:0] stored_distance;
	logic [TICK_W-1:0] ticks_since_frame;

	result_t     pending_reports [$];
	result_t     want;
	int unsigned fail_count;
	int unsigned words_sent;
	int unsigned status_seen [6];
	int unsigned stale_seen;
	int unsigned cycle_count;
	int unsigned burst_left;
	bit          gaps_on;
	int unsigned ready_cnt;
	int unsigned ready_style;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic logic [DIST_W-1:0] decode_distance();
		int unsigned acc;
		acc = 0;
		for (int i = 0; i < DIGITS; i++) begin
			if (digit_bytes[i] < ASCII_ZERO || digit_bytes[i] > ASCII_NINE) begin
				break;
			end
			acc = acc * 10 + (digit_bytes[i] - ASCII_ZERO);
		end
		if (acc > DIST_LIMIT) begin
			acc = DIST_LIMIT;
		end
		return DIST_W'(acc);
	endfunction

	function automatic result_t parse_word(item_t w);
		result_t r;
		status_t st;
		logic    fresh;
		if (w.mode == MODE_TICK) begin
			if (ticks_since_frame != '1) begin
				ticks_since_frame++;
			end
			st = ST_TICK;
		end else if (hunt_in_frame && hunt_count >= DIGITS) begin
			if (w.rx_byte == END_BYTE) begin
				stored_distance = decode_distance();
				ticks_since_frame = '0;
				st = ST_FRAME_OK;
			end else begin
				st = ST_BAD_END;
			end
			hunt_in_frame = 1'b0;
			hunt_count = 0;
		end else if (hunt_in_frame) begin
			digit_bytes[hunt_count] = w.rx_byte;
			hunt_count++;
			st = ST_DATA;
		end else if (w.rx_byte == START_BYTE) begin
			hunt_in_frame = 1'b1;
			hunt_count = 0;
			st = ST_START;
		end else begin
			st = ST_DISCARD;
		end
		fresh = ticks_since_frame <= mirror_timeout;
		r.status = st;
		r.distance = fresh ? stored_distance : mirror_max_dist;
		r.fresh = fresh;
		return r;
	endfunction

	// receiver stall patterns, with the style picked at random from four
	always @(negedge clk) begin
		ready_cnt <= ready_cnt + 1;
		if (ready_cnt % 128 == 0) begin
			ready_style <= $urandom_range(0, 3);
		end
		case (ready_style)
			0: result_ready <= 1'b1;
			1: result_ready <= $urandom_range(0, 3) != 0;
			2: result_ready <= (ready_cnt % 7) < 4;
			default: result_ready <= (ready_cnt % 16) == 0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_reports.size() == 0) begin
				$error("result word with nothing expected: status %0d distance %0d fresh %0d",
					result.status, result.distance, result.fresh);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fail_count++;
				end
				if (result.distance !== want.distance) begin
					$error("distance: expected %0d, got %0d", want.distance, result.distance);
					fail_count++;
				end
				if (result.fresh !== want.fresh) begin
					$error("fresh: expected %0d, got %0d", want.fresh, result.fresh);
					fail_count++;
				end
				if (want.status < 6) begin
					status_seen[want.status]++;
				end
				if (!want.fresh) begin
					stale_seen++;
				end
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d words still expected",
			cycle_count, pending_reports.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_word(input mode_t m, input logic [7:0] b);
		item_t w;
		w.mode = m;
		w.rx_byte = b;
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		pending_reports.push_back(parse_word(w));
		words_sent++;
		@(negedge clk);
		if (gaps_on && burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end else if (burst_left != 0) begin
			burst_left--;
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(MODE_BYTE, b);
	endtask

	task automatic send_tick();
		send_word(MODE_TICK, 8'($urandom));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_DIST) begin
			mirror_max_dist = v[DIST_W-1:0];
		end else begin
			mirror_timeout = v;
		end
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_data_byte();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 8) begin
			return 8'(ASCII_ZERO + $urandom_range(0, 9));
		end else if (roll == 8) begin
			return 8'($urandom);
		end
		return START_BYTE;
	endfunction

	// start byte, data bytes with stray ticks, then terminator when the frame is full
	task automatic send_frame(input int unsigned data_len, input bit good_end);
		send_byte(START_BYTE);
		for (int k = 0; k < data_len; k++) begin
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 3)) send_tick();
			end
			send_byte(pick_data_byte());
		end
		if (data_len == DIGITS) begin
			send_byte(good_end ? END_BYTE : 8'($urandom));
		end
	endtask

	task automatic random_stream(input int unsigned n);
		int unsigned stop;
		stop = words_sent + n;
		while (words_sent < stop) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: send_frame(DIGITS, $urandom_range(0, 6) != 0);
				6, 7: repeat ($urandom_range(1, 40)) send_tick();
				8: repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
				default: send_frame($urandom_range(0, DIGITS - 1), 1'b1);
			endcase
		end
	endtask

	task automatic test_reset_values();
		send_tick();
		drain();
	endtask

	task automatic test_frame_cases();
		// good frame
		send_byte(START_BYTE);
		send_byte("1");
		send_byte("2");
		send_byte("3");
		send_byte("4");
		send_byte(END_BYTE);
		// start byte as terminator is not a new start
		send_byte(START_BYTE);
		send_byte(8'h00);
		send_byte("5");
		send_byte("6");
		send_byte(8'hFF);
		send_byte(START_BYTE);
		send_byte("7");
		// start byte inside a frame is data, no leading digit
		send_byte(START_BYTE);
		send_byte(START_BYTE);
		send_byte("9");
		send_byte("9");
		send_byte("9");
		send_byte(END_BYTE);
		drain();
	endtask

	task automatic test_stale_reporting();
		write_reg(REG_MAX_DIST, 32'd9999);
		write_reg(REG_TIMEOUT, 32'd0);
		send_tick();
		drain();
		write_reg(REG_MAX_DIST, 32'hFFFF_FFFF);
		send_tick();
		drain();
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		send_tick();
		drain();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				0: begin
					write_reg(REG_MAX_DIST, 32'd0);
					write_reg(REG_TIMEOUT, 32'd0);
				end
				1: begin
					write_reg(REG_MAX_DIST, 32'd9999);
					write_reg(REG_TIMEOUT, 32'd3);
				end
				2: begin
					write_reg(REG_MAX_DIST, 32'h3FFF);
					write_reg(REG_TIMEOUT, 32'd25);
				end
				3: begin
					write_reg(REG_MAX_DIST, $urandom_range(0, 9999));
					write_reg(REG_TIMEOUT, $urandom_range(0, 40));
				end
				4: begin
					write_reg(REG_MAX_DIST, 32'(MAX_DIST_RST));
					write_reg(REG_TIMEOUT, TIMEOUT_RST);
				end
				default: begin
					write_reg(REG_MAX_DIST, $urandom_range(0, 9999));
					write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
				end
			endcase
			gaps_on = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
			burst_left = $urandom_range(1, 16);
			random_stream(285);
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MAX_DIST;
		cfg_wdata = '0;
		fail_count = 0;
		words_sent = 0;
		stale_seen = 0;
		cycle_count = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		ready_cnt = 0;
		ready_style = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		mirror_max_dist = MAX_DIST_RST;
		mirror_timeout = TIMEOUT_RST;
		hunt_in_frame = 1'b0;
		hunt_count = 0;
		foreach (digit_bytes[i]) digit_bytes[i] = '0;
		stored_distance = '0;
		ticks_since_frame = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_frame_cases();
		test_stale_reporting();
		test_random_traffic();

		$display("sent %0d words over 10 register settings: %0d good frames, %0d bad terminators",
			words_sent, status_seen[ST_FRAME_OK], status_seen[ST_BAD_END]);
		$display("data %0d, starts %0d, discards %0d, ticks %0d, stale reports %0d",
			status_seen[ST_DATA], status_seen[ST_START], status_seen[ST_DISCARD],
			status_seen[ST_TICK], stale_seen);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
